// File: hdl/rlff_pkg.sv
`timescale 1ns / 1ps
// rlff_pkg: shared constants, codes and the exp table generator for the fire flux pipeline
package rlff_pkg;

    localparam int SQRT_STEPS   = 32;
    localparam int T_BITS       = 17;
    localparam int LIN_BITS     = 32;
    localparam int QUAD_LAT     = 5;
    localparam int EXP_CHAIN    = 22;
    localparam int EXP_LAT      = EXP_CHAIN + 4;
    localparam int CURVE_LAT    = T_BITS + EXP_LAT;
    localparam int TAYLOR_TERMS = 20;

    localparam logic [31:0] SAT32   = 32'hFFFF_FFFF;
    localparam longint      ONE_Q31 = 64'sd2147483648;

    typedef enum logic [2:0] {
        CFG_PEAK_FLUX    = 3'd0,
        CFG_INNER_RADIUS = 3'd1,
        CFG_OUTER_RADIUS = 3'd2,
        CFG_QUAD_ONE     = 3'd3,
        CFG_QUAD_TWO     = 3'd4,
        CFG_DECAY_RATE   = 3'd5,
        CFG_CENTER_AXIS  = 3'd6,
        CFG_CURVE_KIND   = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CURVE_UNIFORM = 2'd0,
        CURVE_LINEAR  = 2'd1,
        CURVE_QUAD    = 2'd2,
        CURVE_EXP     = 2'd3
    } t_curve;

    localparam logic [1:0] AXIS_ONE = 2'd1;
    localparam logic [1:0] AXIS_TWO = 2'd2;

    // shift-and-subtract quotient of a nonnegative 63-bit value; elaboration only
    function automatic longint udiv63(input longint num, input longint den);
        longint quo;
        longint rem;
        quo = 0;
        rem = 0;
        for (int b = 62; b >= 0; b--) begin
            rem = (rem <<< 1) | ((num >>> b) & 64'sd1);
            quo = quo <<< 1;
            if (rem >= den) begin
                rem = rem - den;
                quo = quo | 64'sd1;
            end
        end
        return quo;
    endfunction

    // exp(-x) in Q1.31 from a truncated Taylor sum; x in Q1.31, elaboration only
    function automatic logic [31:0] exp_q31(input longint x);
        longint term;
        longint sum;
        longint prod;
        longint mag;
        term = ONE_Q31;
        sum  = ONE_Q31;
        for (int k = 1; k <= TAYLOR_TERMS; k++) begin
            // each term rounds toward zero
            prod = term * x;
            mag  = (prod < 0) ? -prod : prod;
            mag  = udiv63(mag, longint'(k) * ONE_Q31);
            term = (prod < 0) ? mag : -mag;
            sum  = sum + term;
        end
        if (sum < 0) sum = 0;
        if (sum > ONE_Q31) sum = ONE_Q31;
        return sum[31:0];
    endfunction

endpackage

// File: hdl/rlff_delay.sv
`timescale 1ns / 1ps
// rlff_delay: enabled shift line that aligns side data with the long pipeline paths
module rlff_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);

    logic [WIDTH-1:0] r_tap [DEPTH];

    for (genvar k = 0; k < DEPTH; k++) begin : g_tap
        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (i_en) r_tap[k] <= i_d;
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (i_en) r_tap[k] <= r_tap[k-1];
            end
        end
    end

    assign o_q = r_tap[DEPTH-1];

endmodule

// File: hdl/rlff_sqrt.sv
`timescale 1ns / 1ps
// rlff_sqrt: pipelined digit-by-digit integer square root, one root bit per stage
module rlff_sqrt (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [2*rlff_pkg::SQRT_STEPS-1:0] i_val,
    output logic [rlff_pkg::SQRT_STEPS-1:0]   o_root
);

    localparam int NS = rlff_pkg::SQRT_STEPS;
    localparam int VW = 2 * NS;
    localparam int RW = NS + 2;

    logic [RW-1:0] r_rem  [NS-1];
    logic [VW-1:0] r_val  [NS-1];
    logic [NS-1:0] r_root [NS];

    for (genvar k = 0; k < NS; k++) begin : g_stg
        logic [RW-1:0] w_rem_in;
        logic [VW-1:0] w_val_in;
        logic [NS-1:0] w_root_in;
        logic [RW-1:0] w_rem_s;
        logic [RW-1:0] w_trial;
        logic          w_ge;

        if (k == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_val_in  = i_val;
            assign w_root_in = '0;
        end else begin : g_next
            assign w_rem_in  = r_rem[k-1];
            assign w_val_in  = r_val[k-1];
            assign w_root_in = r_root[k-1];
        end

        // remainder stays below 2^(k+1), so the top two bits are free
        assign w_rem_s = {w_rem_in[RW-3:0], w_val_in[VW-1:VW-2]};
        assign w_trial = {w_root_in, 2'b01};
        assign w_ge    = (w_rem_s >= w_trial);

        always_ff @(posedge i_clk) begin
            if (i_en) r_root[k] <= {w_root_in[NS-2:0], w_ge};
        end

        if (k < NS - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= w_ge ? (w_rem_s - w_trial) : w_rem_s;
                    r_val[k] <= {w_val_in[VW-3:0], 2'b00};
                end
            end
        end
    end

    assign o_root = r_root[NS-1];

endmodule

// File: hdl/rlff_divu.sv
`timescale 1ns / 1ps
// rlff_divu: pipelined restoring unsigned divider, one quotient bit per stage
module rlff_divu #(
    parameter int DW = 32,
    parameter int QB = 17
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [DW-1:0] i_hi,
    input  logic [QB-1:0] i_lo,
    input  logic [DW-1:0] i_div,
    output logic [QB-1:0] o_quo
);

    logic [DW-1:0] r_rem [QB-1];
    logic [DW-1:0] r_div [QB-1];
    logic [QB-1:0] r_quo [QB];

    for (genvar k = 0; k < QB; k++) begin : g_stg
        logic [DW-1:0] w_rem_in;
        logic [DW-1:0] w_div_in;
        logic [QB-1:0] w_quo_in;
        logic [DW:0]   w_rem_s;
        logic [DW:0]   w_diff;
        logic          w_ge;

        if (k == 0) begin : g_first
            assign w_rem_in = i_hi;
            assign w_div_in = i_div;
            assign w_quo_in = i_lo;
        end else begin : g_next
            assign w_rem_in = r_rem[k-1];
            assign w_div_in = r_div[k-1];
            assign w_quo_in = r_quo[k-1];
        end

        // numerator bits shift out of the top while quotient bits fill the bottom
        assign w_rem_s = {w_rem_in, w_quo_in[QB-1]};
        assign w_diff  = w_rem_s - {1'b0, w_div_in};
        assign w_ge    = (w_rem_s >= {1'b0, w_div_in});

        always_ff @(posedge i_clk) begin
            if (i_en) r_quo[k] <= {w_quo_in[QB-2:0], w_ge};
        end

        if (k < QB - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= w_ge ? w_diff[DW-1:0] : w_rem_s[DW-1:0];
                    r_div[k] <= w_div_in;
                end
            end
        end
    end

    assign o_quo = r_quo[QB-1];

endmodule

// File: hdl/rlff_quad.sv
`timescale 1ns / 1ps
// rlff_quad: five-stage quadratic falloff curve and peak scaling with saturation
module rlff_quad (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [16:0]        i_t,
    input  logic signed [23:0] i_k1,
    input  logic signed [23:0] i_k2,
    input  logic [31:0]        i_q,
    output logic [31:0]        o_flux
);

    logic signed [27:0] w_k1;
    logic signed [27:0] w_k2;
    logic signed [27:0] w_c2;
    logic signed [27:0] w_c1;
    logic [63:0]        w_num;
    logic               w_pos;
    logic [31:0]        w_f;

    logic [33:0]        r_tt;
    logic signed [45:0] r_c1t;
    logic signed [62:0] r_n2;
    logic signed [45:0] r_c1t2;
    logic [63:0]        r_num;
    logic [63:0]        r_p;
    logic [31:0]        r_flux;

    assign w_k1 = {{4{i_k1[23]}}, i_k1};
    assign w_k2 = {{4{i_k2[23]}}, i_k2};
    assign w_c2 = (w_k2 - (w_k1 <<< 1) + 28'sd65536) <<< 1;
    assign w_c1 = (w_k1 <<< 2) - w_k2 - 28'sd196608;

    // num = c2*t*t + c1*t*2^16 + 2^48, exact in 64 bits
    assign w_num = {r_n2[62], r_n2} + {{2{r_c1t2[45]}}, r_c1t2, 16'd0}
                 + 64'h0001_0000_0000_0000;
    assign w_pos = !r_num[63] && (r_num != 64'd0);
    assign w_f   = w_pos ? r_num[63:32] : 32'd0;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tt   <= {17'd0, i_t} * {17'd0, i_t};
            r_c1t  <= w_c1 * $signed({1'b0, i_t});
            r_n2   <= w_c2 * $signed({1'b0, r_tt});
            r_c1t2 <= r_c1t;
            r_num  <= w_num;
            r_p    <= {32'd0, i_q} * {32'd0, w_f};
            r_flux <= (|r_p[63:48]) ? rlff_pkg::SAT32 : r_p[47:16];
        end
    end

    assign o_flux = r_flux;

endmodule

// File: hdl/rlff_expo.sv
`timescale 1ns / 1ps
// rlff_expo: exponential decay curve: table lookup, repeated exp(-1) steps, peak scaling
module rlff_expo #(
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [16:0] i_t,
    input  logic [23:0] i_decay,
    input  logic [31:0] i_q,
    output logic [31:0] o_flux
);

    localparam int IW = $clog2(EXP_TABLE_DEPTH);
    localparam int NW = 9;
    localparam int NC = rlff_pkg::EXP_CHAIN;
    localparam logic [31:0] E_ONE = rlff_pkg::exp_q31(rlff_pkg::ONE_Q31);

    logic [31:0]    w_tab [EXP_TABLE_DEPTH];
    logic [40:0]    w_ad;
    logic [16+IW-1:0] w_scl;
    logic [63:0]    w_fp;

    logic [24:0]    r_a;
    logic [IW-1:0]  r_idx;
    logic [NW-1:0]  r_n;
    logic [31:0]    r_v0;
    logic [NW-1:0]  r_n0;
    logic [31:0]    r_v   [NC];
    logic [NW-1:0]  r_cnt [NC-1];
    logic [31:0]    r_flux;

    for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_tab
        localparam longint X = (longint'(g) <<< 31) / EXP_TABLE_DEPTH;
        assign w_tab[g] = rlff_pkg::exp_q31(X);
    end

    assign w_ad  = {17'd0, i_decay} * {24'd0, i_t};
    assign w_scl = {{IW{1'b0}}, r_a[15:0]} * (16+IW)'(EXP_TABLE_DEPTH);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a   <= w_ad[40:16];
            r_idx <= w_scl[16+IW-1:16];
            r_n   <= r_a[24:16];
            r_v0  <= w_tab[r_idx];
            r_n0  <= r_n;
        end
    end

    // each stage multiplies by exp(-1) while steps remain; v reaches zero within NC steps
    for (genvar k = 0; k < NC; k++) begin : g_step
        logic [31:0]   w_v_in;
        logic [NW-1:0] w_n_in;
        logic [63:0]   w_prod;

        if (k == 0) begin : g_first
            assign w_v_in = r_v0;
            assign w_n_in = r_n0;
        end else begin : g_next
            assign w_v_in = r_v[k-1];
            assign w_n_in = r_cnt[k-1];
        end

        assign w_prod = {32'd0, w_v_in} * {32'd0, E_ONE};

        always_ff @(posedge i_clk) begin
            if (i_en) r_v[k] <= (w_n_in > NW'(k)) ? w_prod[62:31] : w_v_in;
        end

        if (k < NC - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) r_cnt[k] <= w_n_in;
            end
        end
    end

    assign w_fp = {32'd0, i_q} * {32'd0, r_v[NC-1]};

    always_ff @(posedge i_clk) begin
        if (i_en) r_flux <= w_fp[62:31];
    end

    assign o_flux = r_flux;

endmodule

// File: hdl/radial_local_fire_flux_top.sv
`timescale 1ns / 1ps
// The pipeline has 81 stages plus the output register; it takes one transaction per
// cycle while o_stall is low.
// Depth is set by the 32-stage square root, the 17-stage position divider and the
// 26-stage exponential path; the linear and quadratic results are delayed to match.
// A one-entry skid behind the output register freezes the pipeline only when it fills.
// Synchronous active-low reset clears all valid bits and loads register defaults.
module radial_local_fire_flux_top #(
    parameter int COORD_WIDTH     = 32,
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [2:0]             i_cfg_index,
    input  logic [31:0]            i_cfg_wdata,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [COORD_WIDTH-1:0] i_node_x,
    input  logic [COORD_WIDTH-1:0] i_node_y,
    input  logic [COORD_WIDTH-1:0] i_node_z,
    input  logic                   i_is_three_d,
    input  logic [COORD_WIDTH-1:0] i_origin_x,
    input  logic [COORD_WIDTH-1:0] i_origin_y,
    input  logic [COORD_WIDTH-1:0] i_origin_z,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [31:0]            o_flux,
    output logic [31:0]            o_radius
);

    localparam int CW       = COORD_WIDTH;
    localparam int DW       = CW + 1;
    localparam int NS       = rlff_pkg::SQRT_STEPS;
    localparam int CLAT     = rlff_pkg::CURVE_LAT;
    localparam int LIN_DLY  = CLAT - rlff_pkg::LIN_BITS;
    localparam int QUAD_DLY = CLAT - rlff_pkg::T_BITS - rlff_pkg::QUAD_LAT;
    localparam int PIPE_LAT = 3 + NS + 1 + 1 + CLAT + 1;

    // configuration
    logic [31:0]        r_cfg_peak;
    logic [31:0]        r_cfg_inner;
    logic [31:0]        r_cfg_outer;
    logic signed [23:0] r_cfg_k1;
    logic signed [23:0] r_cfg_k2;
    logic [23:0]        r_cfg_decay;
    logic [1:0]         r_cfg_axis;
    rlff_pkg::t_curve   r_cfg_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_peak  <= '0;
            r_cfg_inner <= '0;
            r_cfg_outer <= '0;
            r_cfg_k1    <= '0;
            r_cfg_k2    <= '0;
            r_cfg_decay <= '0;
            r_cfg_axis  <= 2'd3;
            r_cfg_kind  <= rlff_pkg::CURVE_LINEAR;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                rlff_pkg::CFG_PEAK_FLUX:    r_cfg_peak  <= i_cfg_wdata;
                rlff_pkg::CFG_INNER_RADIUS: r_cfg_inner <= i_cfg_wdata;
                rlff_pkg::CFG_OUTER_RADIUS: r_cfg_outer <= i_cfg_wdata;
                rlff_pkg::CFG_QUAD_ONE:     r_cfg_k1    <= i_cfg_wdata[23:0];
                rlff_pkg::CFG_QUAD_TWO:     r_cfg_k2    <= i_cfg_wdata[23:0];
                rlff_pkg::CFG_DECAY_RATE:   r_cfg_decay <= i_cfg_wdata[23:0];
                rlff_pkg::CFG_CENTER_AXIS:  r_cfg_axis  <= i_cfg_wdata[1:0];
                rlff_pkg::CFG_CURVE_KIND:   r_cfg_kind  <= rlff_pkg::t_curve'(i_cfg_wdata[1:0]);
                default: ;
            endcase
        end
    end

    // flow control
    logic                r_out_vld;
    logic                r_skid_vld;
    logic [31:0]         r_out_flux;
    logic [31:0]         r_out_rad;
    logic [31:0]         r_skid_flux;
    logic [31:0]         r_skid_rad;
    logic [PIPE_LAT-1:0] r_vld;
    logic                w_en;
    logic                w_acc;

    assign w_en    = !r_skid_vld;
    assign o_stall = r_skid_vld;
    assign w_acc   = i_valid && w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], w_acc};
        end
    end

    // projection and magnitudes
    logic [DW-1:0] w_dx, w_dy, w_dz, w_oz, w_da, w_db;
    logic [63:0]   w_da64, w_db64, w_ma64, w_mb64;
    logic          w_sat;

    assign w_dx = {i_origin_x[CW-1], i_origin_x} - {i_node_x[CW-1], i_node_x};
    assign w_dy = {i_origin_y[CW-1], i_origin_y} - {i_node_y[CW-1], i_node_y};
    assign w_dz = {i_origin_z[CW-1], i_origin_z} - {i_node_z[CW-1], i_node_z};
    assign w_oz = {i_origin_z[CW-1], i_origin_z};

    always_comb begin
        case (r_cfg_axis)
            rlff_pkg::AXIS_ONE: begin
                w_da = w_dy;
                w_db = i_is_three_d ? w_dz : w_oz;
            end
            rlff_pkg::AXIS_TWO: begin
                w_da = w_dx;
                w_db = i_is_three_d ? w_dz : w_oz;
            end
            default: begin
                w_da = w_dx;
                w_db = w_dy;
            end
        endcase
    end

    assign w_da64 = {{(64-DW){w_da[DW-1]}}, w_da};
    assign w_db64 = {{(64-DW){w_db[DW-1]}}, w_db};
    assign w_ma64 = w_da64[63] ? (64'd0 - w_da64) : w_da64;
    assign w_mb64 = w_db64[63] ? (64'd0 - w_db64) : w_db64;
    assign w_sat  = (|w_ma64[63:32]) || (|w_mb64[63:32]);

    logic [31:0] r_s1_ma, r_s1_mb;
    logic        r_s1_sat, r_s2_sat, r_s3_sat;
    logic [63:0] r_s2_sqa, r_s2_sqb, r_s3_sq;
    logic [64:0] w_sum;

    assign w_sum = {1'b0, r_s2_sqa} + {1'b0, r_s2_sqb};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_ma  <= w_ma64[31:0];
            r_s1_mb  <= w_mb64[31:0];
            r_s1_sat <= w_sat;
            r_s2_sqa <= {32'd0, r_s1_ma} * {32'd0, r_s1_ma};
            r_s2_sqb <= {32'd0, r_s1_mb} * {32'd0, r_s1_mb};
            r_s2_sat <= r_s1_sat;
            r_s3_sq  <= w_sum[63:0];
            r_s3_sat <= r_s2_sat || w_sum[64];
        end
    end

    // radius
    logic [31:0] w_root;
    logic        w_sat_d;
    logic [31:0] r_rad;

    rlff_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_val  (r_s3_sq),
        .o_root (w_root)
    );

    rlff_delay #(.WIDTH(1), .DEPTH(NS)) u_sat_dly (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (r_s3_sat),
        .o_q   (w_sat_d)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) r_rad <= w_sat_d ? rlff_pkg::SAT32 : w_root;
    end

    // zone test and curve setup
    logic [31:0] w_d2r;
    logic [31:0] r_c0_rd1, r_c0_len, r_c0_rad;
    logic [63:0] r_c0_prod;
    logic        r_c0_full, r_c0_curve;

    assign w_d2r = r_cfg_outer - r_rad;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c0_rd1   <= r_rad - r_cfg_inner;
            r_c0_len   <= r_cfg_outer - r_cfg_inner;
            r_c0_prod  <= {32'd0, r_cfg_peak} * {32'd0, w_d2r};
            r_c0_rad   <= r_rad;
            r_c0_full  <= (r_cfg_kind == rlff_pkg::CURVE_UNIFORM) || (r_rad <= r_cfg_inner);
            r_c0_curve <= (r_rad <= r_cfg_outer);
        end
    end

    // curve position t = ((r - d1) << 16) / (d2 - d1), Q1.16
    logic [rlff_pkg::T_BITS-1:0]   w_t;
    logic [rlff_pkg::LIN_BITS-1:0] w_lin, w_lin_d;
    logic [31:0]                   w_quad, w_quad_d, w_exp;
    logic [33:0]                   w_side_d;

    rlff_divu #(.DW(32), .QB(rlff_pkg::T_BITS)) u_div_t (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_hi  ({1'b0, r_c0_rd1[31:1]}),
        .i_lo  ({r_c0_rd1[0], {(rlff_pkg::T_BITS-1){1'b0}}}),
        .i_div (r_c0_len),
        .o_quo (w_t)
    );

    rlff_divu #(.DW(32), .QB(rlff_pkg::LIN_BITS)) u_div_lin (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_hi  (r_c0_prod[63:32]),
        .i_lo  (r_c0_prod[31:0]),
        .i_div (r_c0_len),
        .o_quo (w_lin)
    );

    rlff_quad u_quad (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_t    (w_t),
        .i_k1   (r_cfg_k1),
        .i_k2   (r_cfg_k2),
        .i_q    (r_cfg_peak),
        .o_flux (w_quad)
    );

    rlff_expo #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_expo (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_t     (w_t),
        .i_decay (r_cfg_decay),
        .i_q     (r_cfg_peak),
        .o_flux  (w_exp)
    );

    rlff_delay #(.WIDTH(32), .DEPTH(LIN_DLY)) u_lin_dly (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (w_lin),
        .o_q   (w_lin_d)
    );

    rlff_delay #(.WIDTH(32), .DEPTH(QUAD_DLY)) u_quad_dly (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (w_quad),
        .o_q   (w_quad_d)
    );

    rlff_delay #(.WIDTH(34), .DEPTH(CLAT)) u_side_dly (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   ({r_c0_rad, r_c0_full, r_c0_curve}),
        .o_q   (w_side_d)
    );

    // final selection
    logic [31:0] n_fin_flux;
    logic [31:0] r_fin_flux, r_fin_rad;

    always_comb begin
        if (w_side_d[1]) begin
            n_fin_flux = r_cfg_peak;
        end else if (!w_side_d[0]) begin
            n_fin_flux = 32'd0;
        end else begin
            case (r_cfg_kind)
                rlff_pkg::CURVE_LINEAR: n_fin_flux = w_lin_d;
                rlff_pkg::CURVE_QUAD:   n_fin_flux = w_quad_d;
                rlff_pkg::CURVE_EXP:    n_fin_flux = w_exp;
                default:                n_fin_flux = r_cfg_peak;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fin_flux <= n_fin_flux;
            r_fin_rad  <= w_side_d[33:2];
        end
    end

    // output register with one-entry skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (!i_stall) begin
                r_out_flux <= r_skid_flux;
                r_out_rad  <= r_skid_rad;
                r_skid_vld <= 1'b0;
            end
        end else if (r_vld[PIPE_LAT-1]) begin
            if (!r_out_vld || !i_stall) begin
                r_out_flux <= r_fin_flux;
                r_out_rad  <= r_fin_rad;
                r_out_vld  <= 1'b1;
            end else begin
                r_skid_flux <= r_fin_flux;
                r_skid_rad  <= r_fin_rad;
                r_skid_vld  <= 1'b1;
            end
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_valid  = r_out_vld;
    assign o_flux   = r_out_flux;
    assign o_radius = r_out_rad;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid holds a transaction while output register is empty");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[PIPE_LAT-1] && !r_skid_vld && r_out_vld && i_stall) |=> r_skid_vld)
        else $error("transaction leaving pipeline was not caught by skid");

    a_pipe_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_vld && $past(i_rst_n)) |=> $stable(r_vld))
        else $error("pipeline advanced while skid was full");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_out_vld && !r_skid_vld && (r_vld == '0)))
        else $error("valid state not cleared by reset");

endmodule

// File: tb/sv/radial_local_fire_flux_top_tb.sv
`timescale 1ns / 1ps
// radial_local_fire_flux_top_tb: self-checking bench for the local fire flux pipeline
module radial_local_fire_flux_top_tb;

    localparam int CW         = 32;
    localparam int EXP_DEPTH  = 256;
    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_LEN   = 400;

    typedef struct packed {
        logic [CW-1:0] nx, ny, nz;
        logic          three_d;
        logic [CW-1:0] ox, oy, oz;
    } t_node;

    typedef struct packed {
        logic [31:0] flux;
        logic [31:0] radius;
    } t_flux;

    logic          i_clk, i_rst_n;
    logic          i_cfg_wr_en;
    logic [2:0]    i_cfg_index;
    logic [31:0]   i_cfg_wdata;
    logic          i_valid, o_stall;
    logic [CW-1:0] i_node_x, i_node_y, i_node_z;
    logic          i_is_three_d;
    logic [CW-1:0] i_origin_x, i_origin_y, i_origin_z;
    logic          o_valid, i_stall;
    logic [31:0]   o_flux, o_radius;

    radial_local_fire_flux_top #(.COORD_WIDTH(CW), .EXP_TABLE_DEPTH(EXP_DEPTH)) dut (.*);

    // shadow of the register file
    logic [31:0] peak_q, d_inner, d_outer;
    longint      k_one, k_two;
    logic [23:0] decay;
    logic [1:0]  axis;
    logic [1:0]  kind;

    longint exp_tab[0:EXP_DEPTH];

    t_node pending_nodes[$];
    t_flux expected_flux[$];
    int    err_count;
    int    idle_mode;   // 0 none, 1 sender, 2 receiver, 3 both light
    int    hold_req, hold_seen, hold_cnt;
    logic  in_taken;
    int    quiet_cycles;

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    function automatic logic [63:0] floor_sqrt(logic [63:0] v);
        logic [63:0] res, trial;
        res = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = res | (64'd1 << b);
            if (trial * trial <= v) res = trial;
        end
        return res;
    endfunction

    function automatic logic [63:0] curve_value(logic [63:0] r);
        logic [63:0] q, d1, d2, len, t, a, n, idx, v, f, p;
        longint c2, c1, ti, num;
        q = peak_q; d1 = d_inner; d2 = d_outer;
        len = d2 - d1;
        t = ((r - d1) << 16) / len;
        case (rlff_pkg::t_curve'(kind))
            rlff_pkg::CURVE_LINEAR: return (q * (d2 - r)) / len;
            rlff_pkg::CURVE_QUAD: begin
                c2 = 2 * (k_two - 2 * k_one + 65536);
                c1 = -k_two + 4 * k_one - 196608;
                ti = longint'(t);
                num = c2 * ti * ti + c1 * ti * 65536 + (64'sd1 <<< 48);
                if (num <= 0) return 0;
                f = 64'(num) >> 32;
                p = (q * f) >> 16;
                return (p > 64'(rlff_pkg::SAT32)) ? 64'(rlff_pkg::SAT32) : p;
            end
            default: begin
                a = (64'(decay) * t) >> 16;
                n = a >> 16;
                idx = ((a & 64'hFFFF) * EXP_DEPTH) >> 16;
                v = 64'(exp_tab[idx]);
                for (longint i = 0; i < n && v != 0; i++)
                    v = (v * 64'(exp_tab[EXP_DEPTH])) >> 31;
                return (q * v) >> 31;
            end
        endcase
    endfunction

    function automatic t_flux node_flux(t_node nd);
        longint      da, db;
        logic [63:0] ma, mb, sa, sb;
        logic [64:0] s;
        logic [63:0] r, fl;
        t_flux       res;
        if (axis == rlff_pkg::AXIS_ONE || axis == rlff_pkg::AXIS_TWO) begin
            da = (axis == rlff_pkg::AXIS_ONE)
                 ? longint'($signed(nd.oy)) - longint'($signed(nd.ny))
                 : longint'($signed(nd.ox)) - longint'($signed(nd.nx));
            db = nd.three_d ? longint'($signed(nd.oz)) - longint'($signed(nd.nz))
                            : longint'($signed(nd.oz));
        end else begin
            da = longint'($signed(nd.ox)) - longint'($signed(nd.nx));
            db = longint'($signed(nd.oy)) - longint'($signed(nd.ny));
        end
        ma = (da < 0) ? 64'(-da) : 64'(da);
        mb = (db < 0) ? 64'(-db) : 64'(db);
        if (ma > 64'(rlff_pkg::SAT32) || mb > 64'(rlff_pkg::SAT32)) begin
            r = 64'(rlff_pkg::SAT32);
        end else begin
            sa = ma * ma;
            sb = mb * mb;
            s = {1'b0, sa} + {1'b0, sb};
            r = s[64] ? 64'(rlff_pkg::SAT32) : floor_sqrt(s[63:0]);
        end
        if (rlff_pkg::t_curve'(kind) == rlff_pkg::CURVE_UNIFORM || r <= 64'(d_inner))
            fl = peak_q;
        else if (r <= 64'(d_outer)) fl = curve_value(r);
        else fl = 0;
        res.flux = fl[31:0];
        res.radius = r[31:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    task automatic write_reg(rlff_pkg::t_cfg_idx idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        case (idx)
            rlff_pkg::CFG_PEAK_FLUX:    peak_q = data;
            rlff_pkg::CFG_INNER_RADIUS: d_inner = data;
            rlff_pkg::CFG_OUTER_RADIUS: d_outer = data;
            rlff_pkg::CFG_QUAD_ONE:     k_one = longint'($signed(data[23:0]));
            rlff_pkg::CFG_QUAD_TWO:     k_two = longint'($signed(data[23:0]));
            rlff_pkg::CFG_DECAY_RATE:   decay = data[23:0];
            rlff_pkg::CFG_CENTER_AXIS:  axis = data[1:0];
            default:                    kind = data[1:0];
        endcase
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic push_node(logic [31:0] nx, ny, nz, logic td, logic [31:0] ox, oy, oz);
        t_node nd;
        nd = '{nx, ny, nz, td, ox, oy, oz};
        pending_nodes.push_back(nd);
    endtask

    function automatic logic [31:0] rnd_off(logic [31:0] span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    // mostly nodes scattered around the flux zones, some fully random coordinates
    task automatic push_random_node();
        logic [31:0] span, ox, oy, oz;
        logic        td;
        if ($urandom_range(0, 99) < 25) begin
            push_node($urandom, $urandom, $urandom, $urandom_range(0, 1),
                      $urandom, $urandom, $urandom);
        end else begin
            span = (d_outer > 0 && d_outer < 32'h3000_0000 && d_outer >= d_inner)
                   ? d_outer + d_outer / 4 + 32'd16 : 32'h0100_0000;
            ox = rnd_off(32'h1000_0000);
            oy = rnd_off(32'h1000_0000);
            td = $urandom_range(0, 1);
            oz = td ? rnd_off(32'h1000_0000) : rnd_off(span);
            push_node(ox + rnd_off(span), oy + rnd_off(span), oz + rnd_off(span), td,
                      ox, oy, oz);
        end
    endtask

    task automatic setup_phase(int p);
        case (p)
            0: begin
                write_reg(rlff_pkg::CFG_PEAK_FLUX, 32'h0064_0000);
                write_reg(rlff_pkg::CFG_INNER_RADIUS, 32'h0002_0000);
                write_reg(rlff_pkg::CFG_OUTER_RADIUS, 32'h000A_0000);
                write_reg(rlff_pkg::CFG_QUAD_ONE, 32'h0);
                write_reg(rlff_pkg::CFG_QUAD_TWO, 32'h0);
                write_reg(rlff_pkg::CFG_DECAY_RATE, 32'h0002_0000);
                write_reg(rlff_pkg::CFG_CENTER_AXIS, 32'd3);
                write_reg(rlff_pkg::CFG_CURVE_KIND, rlff_pkg::CURVE_LINEAR);
            end
            1: begin
                write_reg(rlff_pkg::CFG_PEAK_FLUX, rlff_pkg::SAT32);
                write_reg(rlff_pkg::CFG_INNER_RADIUS, 32'h0);
                write_reg(rlff_pkg::CFG_OUTER_RADIUS, rlff_pkg::SAT32);
                write_reg(rlff_pkg::CFG_QUAD_ONE, 32'h0080_0000);
                write_reg(rlff_pkg::CFG_QUAD_TWO, 32'h007F_FFFF);
                write_reg(rlff_pkg::CFG_CENTER_AXIS, rlff_pkg::AXIS_ONE);
                write_reg(rlff_pkg::CFG_CURVE_KIND, rlff_pkg::CURVE_QUAD);
            end
            2: begin
                write_reg(rlff_pkg::CFG_INNER_RADIUS, 32'h0001_0000);
                write_reg(rlff_pkg::CFG_OUTER_RADIUS, 32'h0008_0000);
                write_reg(rlff_pkg::CFG_QUAD_ONE, 32'h007F_FFFF);
                write_reg(rlff_pkg::CFG_QUAD_TWO, 32'h0080_0000);
                write_reg(rlff_pkg::CFG_CENTER_AXIS, rlff_pkg::AXIS_TWO);
            end
            3: begin
                write_reg(rlff_pkg::CFG_DECAY_RATE, 32'h00FF_FFFF);
                write_reg(rlff_pkg::CFG_CENTER_AXIS, 32'd0);   // invalid axis, acts as the third
                write_reg(rlff_pkg::CFG_CURVE_KIND, rlff_pkg::CURVE_EXP);
            end
            4: begin
                write_reg(rlff_pkg::CFG_PEAK_FLUX, 32'h0);
                write_reg(rlff_pkg::CFG_DECAY_RATE, 32'h0);
                write_reg(rlff_pkg::CFG_CENTER_AXIS, 32'd3);
            end
            5: begin
                write_reg(rlff_pkg::CFG_PEAK_FLUX, $urandom);
                write_reg(rlff_pkg::CFG_CURVE_KIND, rlff_pkg::CURVE_UNIFORM);
                write_reg(rlff_pkg::CFG_CENTER_AXIS, rlff_pkg::AXIS_TWO);
            end
            6: begin
                // outer edge inside the inner one: no curve region
                write_reg(rlff_pkg::CFG_INNER_RADIUS, 32'h0010_0000);
                write_reg(rlff_pkg::CFG_OUTER_RADIUS, 32'h0004_0000);
                write_reg(rlff_pkg::CFG_CURVE_KIND, rlff_pkg::CURVE_LINEAR);
                write_reg(rlff_pkg::CFG_CENTER_AXIS, rlff_pkg::AXIS_ONE);
            end
            default: begin
                write_reg(rlff_pkg::CFG_PEAK_FLUX, $urandom);
                write_reg(rlff_pkg::CFG_INNER_RADIUS, $urandom_range(0, 32'h0040_0000));
                write_reg(rlff_pkg::CFG_OUTER_RADIUS,
                          d_inner + $urandom_range(0, 32'h0100_0000));
                write_reg(rlff_pkg::CFG_QUAD_ONE, $urandom);
                write_reg(rlff_pkg::CFG_QUAD_TWO, $urandom);
                write_reg(rlff_pkg::CFG_DECAY_RATE, $urandom);
                write_reg(rlff_pkg::CFG_CENTER_AXIS, $urandom_range(0, 3));
                write_reg(rlff_pkg::CFG_CURVE_KIND, $urandom_range(0, 3));
            end
        endcase
    endtask

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || in_taken)) begin
            if (pending_nodes.size() > 0 &&
                !((idle_mode == 1 && $urandom_range(0, 99) < 57) ||
                  (idle_mode == 3 && $urandom_range(0, 99) < 8))) begin
                t_node nd;
                nd = pending_nodes.pop_front();
                i_node_x     <= nd.nx;
                i_node_y     <= nd.ny;
                i_node_z     <= nd.nz;
                i_is_three_d <= nd.three_d;
                i_origin_x   <= nd.ox;
                i_origin_y   <= nd.oy;
                i_origin_z   <= nd.oz;
                i_valid      <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver stall, with an occasional long hold-off
    always @(negedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_cnt = HOLD_LEN;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= (idle_mode == 2 && $urandom_range(0, 99) < 57) ||
                       (idle_mode == 3 && $urandom_range(0, 99) < 8);
        end
    end

    // monitor: predict on input transactions, check on output transactions
    always @(posedge i_clk) begin
        t_node nd;
        t_flux want;
        in_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall) begin
            nd = '{i_node_x, i_node_y, i_node_z, i_is_three_d,
                   i_origin_x, i_origin_y, i_origin_z};
            expected_flux.push_back(node_flux(nd));
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_flux.size() == 0) begin
                $display("unexpected output transaction at %0t", $realtime);
                err_count++;
            end else begin
                want = expected_flux.pop_front();
                if (o_flux !== want.flux) report_mismatch("flux", o_flux, want.flux);
                if (o_radius !== want.radius)
                    report_mismatch("radius", o_radius, want.radius);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("radial_local_fire_flux_top_tb: FAIL");
            $finish;
        end
    end

    initial begin
        longint x, term, sum;
        for (int i = 0; i <= EXP_DEPTH; i++) begin
            x = (longint'(i) <<< 31) / EXP_DEPTH;
            term = rlff_pkg::ONE_Q31;
            sum = rlff_pkg::ONE_Q31;
            for (int k = 1; k <= rlff_pkg::TAYLOR_TERMS; k++) begin
                term = -(term * x) / (longint'(k) * rlff_pkg::ONE_Q31);
                sum += term;
            end
            if (sum < 0) sum = 0;
            if (sum > rlff_pkg::ONE_Q31) sum = rlff_pkg::ONE_Q31;
            exp_tab[i] = sum;
        end
        peak_q = 0; d_inner = 0; d_outer = 0; k_one = 0; k_two = 0; decay = 0;
        axis = 2'd3; kind = rlff_pkg::CURVE_LINEAR;
        err_count = 0; idle_mode = 0; hold_req = 0; hold_seen = 0; hold_cnt = 0;
        in_taken = 0; quiet_cycles = 0;
        i_rst_n = 0; i_cfg_wr_en = 0; i_cfg_index = rlff_pkg::CFG_PEAK_FLUX; i_cfg_wdata = 0;
        i_valid = 0; i_stall = 0;
        i_node_x = 0; i_node_y = 0; i_node_z = 0; i_is_three_d = 0;
        i_origin_x = 0; i_origin_y = 0; i_origin_z = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < 12; p++) begin
            wait (pending_nodes.size() == 0 && expected_flux.size() == 0 && !i_valid);
            repeat (4) @(negedge i_clk);
            setup_phase(p);
            idle_mode = (p == 7) ? 0 : p % 4;
            if (p == 0) begin
                // center, zone edges, extreme coordinates, 2D origin_z extremes
                push_node(0, 0, 0, 1, 0, 0, 0);
                push_node(32'h0002_0000, 0, 5, 1, 0, 0, 0);
                push_node(32'h0002_0001, 0, 0, 0, 0, 0, 0);
                push_node(32'h0006_0000, 0, 0, 1, 0, 0, 0);
                push_node(32'h000A_0000, 0, 0, 1, 0, 0, 0);
                push_node(32'h000A_0001, 0, 0, 1, 0, 0, 0);
                push_node(0, 32'hFFF9_0000, 0, 1, 0, 0, 0);
                push_node(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
                push_node(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0,
                          32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
                push_node(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
                push_node(32'hFFFF_FFFF, 0, 32'h1234_5678, 0, 0, 0, 32'h8000_0000);
                push_node(32'h0000_8000, 32'h0001_8000, 0, 1, 0, 0, 0);
                push_node(32'h8000_0000, 0, 0, 1, 0, 0, 0);
                push_node(0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
            end
            if (p == 7) hold_req++;
            for (int n = 0; n < 92; n++) push_random_node();
        end

        wait (pending_nodes.size() == 0 && expected_flux.size() == 0 && !i_valid);
        repeat (100) @(posedge i_clk);
        if (err_count == 0)
            $display("radial_local_fire_flux_top_tb: PASS");
        else
            $display("radial_local_fire_flux_top_tb: FAIL");
        $finish;
    end

endmodule
